// ===== rtl/cpu_control_stack_instruction_unit_top_assert.svh =====
// Assertion macros used by the checker file.
`ifndef CPU_CONTROL_STACK_INSTRUCTION_UNIT_TOP_ASSERT_SVH
`define CPU_CONTROL_STACK_INSTRUCTION_UNIT_TOP_ASSERT_SVH
`define CSIU_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define CSIU_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`endif

// ===== rtl/csiu_pkg.sv =====
// ---------------------------------------------------------------------------
// csiu_pkg
// Shared types and constants of the control/stack instruction unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package csiu_pkg;
   localparam int ADDR_BITS_DEF = 24;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_HALT  = 2'd1;
   localparam logic [1:0] ST_UNIMP = 2'd2;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [31:0] operand;
      logic [47:0] stack_bytes;
      logic [31:0] vector_word;
   } req_type;

   typedef struct packed {
      logic        write_valid;
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic [2:0]  write_size;
      logic [31:0] next_pc;
      logic [31:0] stack_pointer;
      logic [4:0]  cycle_count;
      logic [2:0]  instr_length;
      logic [31:0] written_mask;
      logic [1:0]  exec_status;
      logic        last;
   } rsp_type;
endpackage

// ===== rtl/csiu_queue.sv =====
// ---------------------------------------------------------------------------
// csiu_queue
// Two-entry request queue between the front end and the execute stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module csiu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  csiu_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output csiu_pkg::req_type out_data
);
   csiu_pkg::req_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

// ===== rtl/csiu_exec.sv =====
// ---------------------------------------------------------------------------
// csiu_exec
// Execute stage: holds architectural state, retires one instruction per
// cycle into an output register unless stalled; swi holds for its 2nd store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module csiu_exec #(
   parameter int ADDR_BITS = csiu_pkg::ADDR_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  csiu_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output csiu_pkg::rsp_type out_data
);
   localparam logic [31:0] AMASK = 32'hFFFF_FFFF >> (32 - ADDR_BITS);

   logic [31:0] rf_ff [8];
   logic [31:0] bank_ff [16];
   logic [7:0]  flag_ff;
   logic [1:0]  bp_ff;
   logic [2:0]  im_ff;
   logic [31:0] pc_ff;
   logic [15:0] swc_ff;

   csiu_pkg::rsp_type rsp_ff, pend_ff, r0, r1;
   logic vld_ff, pend_vld_ff;

   // next-state
   logic [31:0] rf_in [8];
   logic [7:0]  flag_in;
   logic [2:0]  im_in;
   logic [31:0] pc_in;
   logic [15:0] swc_in;
   logic        sw_en;
   logic [1:0]  sw_nb;
   logic        two;

   logic [7:0]  op;
   logic [31:0] opd, vec, sp, npc, ret, mask, wa0, wd0, wa1, wd1;
   logic [47:0] stk;
   logic [2:0]  r, len, ws0;
   logic [4:0]  cyc;
   logic [1:0]  st;
   logic        nw, s, z, v, c, taken;
   logic [15:0] sr, srin;
   logic [31:0] se8, se16;

   logic fire, can_take;
   assign can_take = !pend_vld_ff && (!vld_ff || out_ready);
   assign in_ready = can_take;
   assign fire = in_valid && can_take;
   assign out_valid = vld_ff;
   assign out_data = rsp_ff;

   always_comb begin
      op = in_data.opcode; opd = in_data.operand;
      stk = in_data.stack_bytes; vec = in_data.vector_word;
      r = op[2:0];
      sp = rf_ff[7];
      for (int i = 0; i < 8; i++) rf_in[i] = rf_ff[i];
      flag_in = flag_ff; im_in = im_ff; pc_in = pc_ff; swc_in = swc_ff;
      sw_en = 1'b0; sw_nb = bp_ff; two = 1'b0;
      nw = 1'b0; wa0 = '0; wd0 = '0; ws0 = '0; wa1 = '0; wd1 = '0;
      len = 3'd1; cyc = '0; st = csiu_pkg::ST_OK; mask = '0;
      npc = pc_ff; ret = '0;
      s = flag_ff[7]; z = flag_ff[6]; v = flag_ff[2]; c = flag_ff[0];
      se8 = {{24{opd[7]}}, opd[7:0]};
      se16 = {{16{opd[15]}}, opd[15:0]};
      sr = {1'b1, im_ff, 1'b1, 1'b0, bp_ff, flag_ff};
      srin = '0;
      unique case (op[3:0])
         4'd0: taken = 1'b0;
         4'd1: taken = s ^ v;
         4'd2: taken = z | (s ^ v);
         4'd3: taken = c | z;
         4'd4: taken = v;
         4'd5: taken = s;
         4'd6: taken = z;
         4'd7: taken = c;
         4'd8: taken = 1'b1;
         4'd9: taken = ~(s ^ v);
         4'd10: taken = ~z & ~(s ^ v);
         4'd11: taken = ~c & ~z;
         4'd12: taken = ~v;
         4'd13: taken = ~s;
         4'd14: taken = ~z;
         default: taken = ~c;
      endcase

      if (op == 8'h00) begin
         cyc = 5'd2;
      end else if (op >= 8'h20 && op <= 8'h27) begin
         if (r[0]) rf_in[r[2:1]][7:0] = opd[7:0];
         else rf_in[r[2:1]][15:8] = opd[7:0];
         len = 3'd2; cyc = 5'd3; mask[r[2:1]] = 1'b1;
      end else if (op >= 8'h30 && op <= 8'h37) begin
         rf_in[r][15:0] = opd[15:0]; len = 3'd3; cyc = 5'd4; mask[r] = 1'b1;
      end else if (op >= 8'h40 && op <= 8'h47) begin
         rf_in[r] = opd; len = 3'd5; cyc = 5'd6; mask[r] = 1'b1;
      end else if (op >= 8'h28 && op <= 8'h2E) begin
         rf_in[7] = sp - 32'd2; wa0 = sp - 32'd2; wd0 = {16'd0, rf_ff[r][15:0]};
         ws0 = 3'd2; nw = 1'b1; cyc = 5'd3; mask[7] = 1'b1;
      end else if (op >= 8'h48 && op <= 8'h4E) begin
         rf_in[r][15:0] = stk[15:0]; rf_in[7] = sp + 32'd2;
         cyc = 5'd4; mask[r] = 1'b1; mask[7] = 1'b1;
      end else if (op >= 8'h38 && op <= 8'h3E) begin
         rf_in[7] = sp - 32'd4; wa0 = sp - 32'd4; wd0 = rf_ff[r];
         ws0 = 3'd4; nw = 1'b1; cyc = 5'd5; mask[7] = 1'b1;
      end else if (op >= 8'h58 && op <= 8'h5E) begin
         rf_in[7] = sp + 32'd4; rf_in[r] = stk[31:0];
         cyc = 5'd6; mask[r] = 1'b1; mask[7] = 1'b1;
      end else if (op == 8'h0E) begin
         npc = stk[31:0]; rf_in[7] = sp + 32'd4; cyc = 5'd9; mask[7] = 1'b1;
      end else if (op == 8'h1E || op == 8'h1C || op == 8'h1D) begin
         len = (op == 8'h1D) ? 3'd4 : 3'd3;
         ret = (pc_ff + {29'd0, len}) & AMASK;
         if (op == 8'h1E) begin npc = (ret + se16) & AMASK; cyc = 5'd10; end
         else if (op == 8'h1C) begin npc = {16'd0, opd[15:0]}; cyc = 5'd9; end
         else begin npc = {8'd0, opd[23:0]}; cyc = 5'd10; end
         rf_in[7] = sp - 32'd4; wa0 = sp - 32'd4; wd0 = ret; ws0 = 3'd4; nw = 1'b1;
         mask[7] = 1'b1;
      end else if (op == 8'h08 || op == 8'h0A) begin
         wa0 = {24'd0, opd[7:0]}; nw = 1'b1;
         if (op == 8'h0A) begin
            wd0 = {16'd0, opd[23:8]}; ws0 = 3'd2; len = 3'd4; cyc = 5'd6;
         end else begin
            wd0 = {24'd0, opd[15:8]}; ws0 = 3'd1; len = 3'd3; cyc = 5'd5;
         end
      end else if (op == 8'h17 || op == 8'h0C || op == 8'h0D) begin
         sw_en = 1'b1;
         sw_nb = (op == 8'h17) ? opd[1:0] : (op == 8'h0C) ? bp_ff + 2'd1 : bp_ff + 2'd3;
         len = (op == 8'h17) ? 3'd2 : 3'd1; cyc = 5'd2;
      end else if (op == 8'h09) begin
         rf_in[7] = sp - 32'd1; wa0 = sp - 32'd1; wd0 = {24'd0, opd[7:0]};
         ws0 = 3'd1; nw = 1'b1; len = 3'd2; cyc = 5'd4; mask[7] = 1'b1;
      end else if (op == 8'h0B) begin
         rf_in[7] = sp - 32'd2; wa0 = sp - 32'd2; wd0 = {16'd0, opd[15:0]};
         ws0 = 3'd2; nw = 1'b1; len = 3'd3; cyc = 5'd5; mask[7] = 1'b1;
      end else if (op == 8'h14 || op == 8'h18) begin
         rf_in[7] = sp - 32'd1; wa0 = sp - 32'd1;
         wd0 = {24'd0, (op == 8'h14) ? rf_ff[0][7:0] : flag_ff};
         ws0 = 3'd1; nw = 1'b1; cyc = 5'd3; mask[7] = 1'b1;
      end else if (op == 8'h15 || op == 8'h19) begin
         rf_in[7] = sp + 32'd1;
         if (op == 8'h15) rf_in[0][7:0] = stk[7:0];
         else flag_in = stk[7:0];
         cyc = 5'd4; mask[7] = 1'b1;
      end else if (op >= 8'hF8) begin
         ret = (pc_ff + 32'd1) & AMASK;
         rf_in[7] = sp - 32'd6;
         wa0 = sp - 32'd2; wd0 = {16'd0, sr}; ws0 = 3'd2; nw = 1'b1;
         wa1 = sp - 32'd6; wd1 = ret; two = 1'b1;
         npc = vec; cyc = 5'd19; mask[7] = 1'b1;
      end else if (op == 8'h05) begin
         st = csiu_pkg::ST_HALT; cyc = 5'd6;
      end else if (op == 8'h02) begin
         rf_in[7] = sp - 32'd2; wa0 = sp - 32'd2; wd0 = {16'd0, sr};
         ws0 = 3'd2; nw = 1'b1; cyc = 5'd3; mask[7] = 1'b1;
      end else if (op == 8'h03 || op == 8'h07) begin
         if (op == 8'h07) begin
            npc = stk[31:0]; srin = stk[47:32]; rf_in[7] = sp + 32'd6; cyc = 5'd12;
         end else begin
            srin = stk[15:0]; rf_in[7] = sp + 32'd2; cyc = 5'd4;
         end
         sw_en = 1'b1; sw_nb = srin[9:8];
         swc_in = srin; flag_in = srin[7:0]; im_in = srin[14:12];
         mask[7] = 1'b1;
      end else if (op == 8'h06) begin
         im_in = opd[2:0]; len = 3'd2;
         cyc = (opd[7:0] == 8'd7) ? 5'd4 : 5'd3;
      end else if (op >= 8'h10 && op <= 8'h13) begin
         flag_in = flag_ff & 8'hFC;
         if (op <= 8'h11) flag_in[4] = 1'b0;
         unique case (op[1:0])
            2'd0: flag_in[0] = 1'b0;
            2'd1: flag_in[0] = 1'b1;
            2'd2: flag_in[0] = ~flag_ff[0];
            default: flag_in[0] = ~flag_ff[6];
         endcase
         cyc = 5'd2; mask[31] = 1'b1;
      end else if (op == 8'h1A) begin
         npc = {16'd0, opd[15:0]}; len = 3'd3; cyc = 5'd5;
      end else if (op == 8'h1B) begin
         npc = {8'd0, opd[23:0]}; len = 3'd4; cyc = 5'd6;
      end else if (op == 8'h0F) begin
         npc = stk[31:0]; rf_in[7] = sp + 32'd4 + se16;
         len = 3'd3; cyc = 5'd11; mask[7] = 1'b1;
      end else if (op >= 8'h60 && op <= 8'h7F) begin
         len = op[4] ? 3'd3 : 3'd2;
         ret = (pc_ff + {29'd0, len}) & AMASK;
         npc = taken ? ((ret + (op[4] ? se16 : se8)) & AMASK) : ret;
         cyc = taken ? 5'd5 : 5'd2;
      end else begin
         st = csiu_pkg::ST_UNIMP;
      end

      if (st == csiu_pkg::ST_OK) begin
         if (!(op >= 8'h60 && op <= 8'h7F) && op != 8'h0E && op != 8'h0F &&
             op != 8'h1A && op != 8'h1B && op != 8'h1C && op != 8'h1D &&
             op != 8'h1E && op != 8'h07 && op < 8'hF8)
            npc = (pc_ff + {29'd0, len}) & AMASK;
         pc_in = npc;
      end

      r0.write_valid = nw; r0.write_address = wa0; r0.write_data = wd0;
      r0.write_size = ws0; r0.next_pc = npc; r0.stack_pointer = rf_in[7];
      r0.cycle_count = cyc; r0.instr_length = len; r0.written_mask = mask;
      r0.exec_status = st; r0.last = !two;
      r1 = r0;
      r1.write_address = wa1; r1.write_data = wd1; r1.write_size = 3'd4;
      r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
         for (int i = 0; i < 16; i++) bank_ff[i] <= '0;
         flag_ff <= '0; bp_ff <= '0; im_ff <= '0; pc_ff <= '0; swc_ff <= '0;
         vld_ff <= 1'b0; pend_vld_ff <= 1'b0;
      end else begin
         if (fire) begin
            flag_ff <= flag_in; im_ff <= im_in; pc_ff <= pc_in; swc_ff <= swc_in;
            if (sw_en && sw_nb != bp_ff) begin
               for (int i = 0; i < 4; i++) begin
                  bank_ff[{bp_ff, i[1:0]}] <= rf_in[i];
                  rf_ff[i] <= bank_ff[{sw_nb, i[1:0]}];
               end
               for (int i = 4; i < 8; i++) rf_ff[i] <= rf_in[i];
               bp_ff <= sw_nb;
            end else begin
               for (int i = 0; i < 8; i++) rf_ff[i] <= rf_in[i];
            end
         end
         if (fire) vld_ff <= 1'b1;
         else if (out_ready && pend_vld_ff) vld_ff <= 1'b1;
         else if (out_ready) vld_ff <= 1'b0;
         if (fire) pend_vld_ff <= two;
         else if (out_ready && vld_ff) pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= r0; pend_ff <= r1;
      end else if (out_ready && vld_ff && pend_vld_ff) begin
         rsp_ff <= pend_ff;
      end
   end
endmodule

// ===== rtl/cpu_control_stack_instruction_unit_top.sv =====
// ---------------------------------------------------------------------------
// cpu_control_stack_instruction_unit_top
// Single-byte-opcode execute unit with a decoupling request queue.
// ---------------------------------------------------------------------------
// One instruction retires per cycle when the response is not stalled: a
// request passes a two-entry queue and is executed into a registered
// response; swi produces two responses and holds the execute stage until
// the second one is taken.
`timescale 1ns / 1ps
module cpu_control_stack_instruction_unit_top #(
   parameter int ADDR_BITS = csiu_pkg::ADDR_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[7:0], operand[39:8], stack_bytes[87:40], vector_word[119:88]
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // write_valid[0], write_address[32:1], write_data[64:33], write_size[67:65],
   // next_pc[99:68], stack_pointer[131:100], cycle_count[136:132],
   // instr_length[139:137], written_mask[171:140], exec_status[173:172]
   output logic [175:0] rsp_tdata,
   output logic         rsp_tlast
);
   csiu_pkg::req_type qin, qout;
   csiu_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   assign qin.opcode = req_tdata[7:0];
   assign qin.operand = req_tdata[39:8];
   assign qin.stack_bytes = req_tdata[87:40];
   assign qin.vector_word = req_tdata[119:88];

   csiu_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(qin),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(qout)
   );

   csiu_exec #(.ADDR_BITS(ADDR_BITS)) u_exec (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(qout),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp)
   );

   assign rsp_tdata = {2'd0, rsp.exec_status, rsp.written_mask, rsp.instr_length,
                       rsp.cycle_count, rsp.stack_pointer, rsp.next_pc,
                       rsp.write_size, rsp.write_data, rsp.write_address,
                       rsp.write_valid};
   assign rsp_tlast = rsp.last;
endmodule

// ===== rtl/csiu_checker.sv =====
// ---------------------------------------------------------------------------
// csiu_checker
// Port-level checks of the instruction unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu_control_stack_instruction_unit_top_assert.svh"
module csiu_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [175:0] rsp_tdata,
   input logic         rsp_tlast
);
   `CSIU_ASSERT_IMPL(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `CSIU_ASSERT_IMPL(a_status, clock, reset, rsp_tvalid |-> rsp_tdata[173:172] != 2'd3)
   `CSIU_ASSERT_IMPL(a_nolast_store, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tdata[0])
   `CSIU_ASSERT_IMPL(a_size, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[67:65] == 3'd0)
   `CSIU_ASSERT_NORST(a_rst, clock, reset |=> !rsp_tvalid)
endmodule

bind cpu_control_stack_instruction_unit_top csiu_checker u_csiu_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
